@@ hdl/alb_pkg.sv @@
// Shared constants, register codes and configuration bundle for the brightness curve block.
package alb_pkg;

  localparam int FILTER_SHIFT = 3;
  localparam int FAIL_LIMIT   = 3;
  localparam int BRIGHT_MAX   = 1000;

  localparam int LUX_W    = 24;
  localparam int BRIGHT_W = 10;
  localparam int WHOLE_W  = 18;  // lux / 100 for a 24-bit reading
  localparam int ROOT_W   = 9;   // floor sqrt of an 18-bit value
  localparam int BASE_W   = 17;  // 8-bit factor times 9-bit root
  localparam int TGT_W    = 18;  // base plus half of base
  localparam int DVSR_W   = 7;
  localparam int CAP_W    = 15;

  localparam int DIV_CYCLES = LUX_W / 2;   // two quotient bits per cycle
  localparam int SQRT_STEPS = WHOLE_W / 2; // one bit pair per cycle

  localparam logic [DVSR_W-1:0] DIVISOR_LUX = 7'd100;
  localparam logic [DVSR_W-1:0] DIVISOR_PCT = 7'd10;

  localparam logic [LUX_W-1:0]    LOW_LIGHT_LIMIT = 24'd10000;
  localparam logic [BRIGHT_W-1:0] BAND_LOW        = 10'd150;
  localparam logic [BRIGHT_W-1:0] BAND_MID        = 10'd400;

  // offset table codes
  localparam logic [7:0] OFS_MINUS_50 = 8'd0;
  localparam logic [7:0] OFS_MINUS_30 = 8'd1;
  localparam logic [7:0] OFS_PLUS_30  = 8'd3;
  localparam logic [7:0] OFS_PLUS_50  = 8'd4;

  typedef enum logic [2:0] {
    REG_SQRT_FACTOR = 3'd0,
    REG_CAP_LOW     = 3'd1,
    REG_CAP_HIGH    = 3'd2,
    REG_MIN_BRIGHT  = 3'd3,
    REG_OFFSET_IDX  = 3'd4,
    REG_SLEW_LOW    = 3'd5,
    REG_SLEW_MID    = 3'd6,
    REG_SLEW_MAX    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]          sqrt_factor;
    logic [7:0]          cap_low_hundreds;
    logic [7:0]          cap_high_hundreds;
    logic [BRIGHT_W-1:0] min_brightness;
    logic [7:0]          offset_index;
    logic [BRIGHT_W-1:0] slew_up_low;
    logic [BRIGHT_W-1:0] slew_up_mid;
    logic [BRIGHT_W-1:0] slew_max;
  } cfg_t;

endpackage

@@ hdl/alb_cfg.sv @@
// Configuration register file for the brightness curve block.
module alb_cfg
  import alb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SQRT_FACTOR: cfg_nxt.sqrt_factor       = cfg_data[7:0];
        REG_CAP_LOW:     cfg_nxt.cap_low_hundreds  = cfg_data[7:0];
        REG_CAP_HIGH:    cfg_nxt.cap_high_hundreds = cfg_data[7:0];
        REG_MIN_BRIGHT:  cfg_nxt.min_brightness    = cfg_data;
        REG_OFFSET_IDX:  cfg_nxt.offset_index      = cfg_data[7:0];
        REG_SLEW_LOW:    cfg_nxt.slew_up_low       = cfg_data;
        REG_SLEW_MID:    cfg_nxt.slew_up_mid       = cfg_data;
        REG_SLEW_MAX:    cfg_nxt.slew_max          = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sqrt_factor       <= 8'd10;
      cfg_r.cap_low_hundreds  <= 8'd5;
      cfg_r.cap_high_hundreds <= 8'd10;
      cfg_r.min_brightness    <= 10'd5;
      cfg_r.offset_index      <= 8'd2;
      cfg_r.slew_up_low       <= 10'd5;
      cfg_r.slew_up_mid       <= 10'd20;
      cfg_r.slew_max          <= 10'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/alb_div.sv @@
// Bit-serial restoring divider by a small constant, two quotient bits per cycle.
module alb_div
  import alb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LUX_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic              done,
  output logic [LUX_W-1:0]  quotient
);

  logic [LUX_W-1:0]  q_r, q_nxt;
  logic [DVSR_W-1:0] rem_r, rem_nxt, dvsr_r;
  logic [3:0]        cnt_r;
  logic              busy_r, done_r;
  logic [DVSR_W:0]   r1, r2;
  logic [DVSR_W-1:0] rem_mid;
  logic              b1, b2;

  always_comb begin
    r1      = {rem_r, q_r[LUX_W-1]};
    b1      = r1 >= {1'b0, dvsr_r};
    rem_mid = b1 ? DVSR_W'(r1 - {1'b0, dvsr_r}) : r1[DVSR_W-1:0];
    r2      = {rem_mid, q_r[LUX_W-2]};
    b2      = r2 >= {1'b0, dvsr_r};
    rem_nxt = b2 ? DVSR_W'(r2 - {1'b0, dvsr_r}) : r2[DVSR_W-1:0];
    q_nxt   = {q_r[LUX_W-3:0], b1, b2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        if (cnt_r == 4'(DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == 4'd0 && !done_r)
    else $error("divider did not restart on start");

endmodule

@@ hdl/alb_sqrt.sv @@
// Digit-serial integer square root, one bit pair of the radicand per cycle.
module alb_sqrt
  import alb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [WHOLE_W-1:0] radicand,
  output logic               done,
  output logic [ROOT_W-1:0]  root
);

  logic [WHOLE_W-1:0] x_r;
  logic [ROOT_W:0]    rem_r;    // remainder never exceeds twice the root
  logic [ROOT_W-1:0]  root_r;
  logic [3:0]         cnt_r;
  logic               busy_r, done_r;
  logic [ROOT_W+2:0]  rem_sh, trial;
  logic               ge;

  always_comb begin
    rem_sh = {rem_r, x_r[WHOLE_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        if (cnt_r == 4'(SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[WHOLE_W-3:0], 2'b00};
      rem_r  <= ge ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

  a_sqrt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= 4'(SQRT_STEPS - 1))
    else $error("square root step count out of range");

endmodule

@@ hdl/ambient_light_brightness_curve_core.sv @@
// Top level: reading filter, curve sequencer, clamps, slew limit and result register.
// A good read runs the divide by 100, the bit-pair square root, the multiply, the offset and the
// clamps; a +/-30 percent offset adds a serial divide by 10, and a failed read goes straight to
// the result. One item in work at a time: in_stall stays high until the result is registered.
// Synchronous active-low reset clears state, loads config defaults.
module ambient_light_brightness_curve_core
  import alb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [LUX_W-1:0]    in_lux_hundredths,
  input  logic                in_read_failed,
  input  logic                in_test_mode,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BRIGHT_W-1:0] out_brightness,
  output logic                out_brightness_valid,
  output logic [LUX_W-1:0]    out_filtered_lux,
  output logic                out_sensor_failed,
  output logic                out_error_raised,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [9:0]          cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DIV1 = 9'b000000010,
    ST_SQRT = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_OFS  = 9'b000010000,
    ST_DIV2 = 9'b000100000,
    ST_FIN1 = 9'b001000000,
    ST_FIN2 = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  cfg_t cfg;

  state_t              state_r, state_nxt;
  logic [LUX_W-1:0]    avg_r;
  logic                seeded_r, last_seeded_r;
  logic [BRIGHT_W-1:0] last_r;
  logic [3:0]          fail_cnt_r;
  logic                failed_r, raise_r, low_light_r, neg_r;
  logic                div_start_r, sqrt_start_r;
  logic [BASE_W-1:0]   base_r, delta_r;
  logic [CAP_W-1:0]    cap_r;
  logic [BRIGHT_W-1:0] tgt_r;

  logic                out_valid_r, out_bvalid_r, out_failed_r, out_err_r;
  logic [BRIGHT_W-1:0] out_bright_r;
  logic [LUX_W-1:0]    out_lux_r;

  logic                in_xfer, out_free;
  logic                div_done, sqrt_done;
  logic [LUX_W-1:0]    div_dividend, div_quot;
  logic [DVSR_W-1:0]   div_divisor;
  logic [ROOT_W-1:0]   root;
  logic [LUX_W-1:0]    avg_nxt;
  logic [3:0]          cnt_inc;
  logic [BASE_W-1:0]   prod;
  logic [BASE_W+1:0]   base3;
  logic [CAP_W-1:0]    cap_sel;
  logic [7:0]          cap_h;
  logic [TGT_W-1:0]    sum, t_min, t_cap, t_full;
  logic [BRIGHT_W-1:0] slew_up, rise, fall, slewed;
  logic [BRIGHT_W:0]   lim_up;

  alb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign base3        = {1'b0, base_r, 1'b0} + {2'b00, base_r};
  assign div_dividend = (state_r == ST_DIV2) ? LUX_W'(base3) : avg_r;
  assign div_divisor  = (state_r == ST_DIV2) ? DIVISOR_PCT : DIVISOR_LUX;

  alb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  alb_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start_r),
    .radicand (div_quot[WHOLE_W-1:0]),
    .done     (sqrt_done),
    .root     (root)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    avg_nxt = seeded_r
      ? LUX_W'(avg_r - (avg_r >> FILTER_SHIFT) + (in_lux_hundredths >> FILTER_SHIFT))
      : in_lux_hundredths;
    cnt_inc = fail_cnt_r + 4'd1;
    prod    = {{(BASE_W-8){1'b0}}, cfg.sqrt_factor} * {{(BASE_W-ROOT_W){1'b0}}, root};
    cap_h   = low_light_r ? cfg.cap_low_hundreds : cfg.cap_high_hundreds;
    // hundreds times 100 as 64 + 32 + 4
    cap_sel = ({cap_h, 6'd0} + {1'b0, cap_h, 5'd0}) + {5'd0, cap_h, 2'd0};

    sum    = neg_r ? ({1'b0, base_r} - {1'b0, delta_r}) : ({1'b0, base_r} + {1'b0, delta_r});
    t_min  = (sum < TGT_W'(cfg.min_brightness)) ? TGT_W'(cfg.min_brightness) : sum;
    t_cap  = (t_min > TGT_W'(cap_r)) ? TGT_W'(cap_r) : t_min;
    t_full = (t_cap > TGT_W'(BRIGHT_MAX)) ? TGT_W'(BRIGHT_MAX) : t_cap;

    if (last_r < BAND_LOW)       slew_up = cfg.slew_up_low;
    else if (last_r < BAND_MID)  slew_up = cfg.slew_up_mid;
    else                         slew_up = cfg.slew_max;
    rise   = tgt_r - last_r;
    fall   = last_r - tgt_r;
    lim_up = {1'b0, last_r} + {1'b0, slew_up};
    slewed = tgt_r;
    if (last_seeded_r) begin
      if (tgt_r > last_r) begin
        if (rise > slew_up) slewed = lim_up[BRIGHT_W-1:0];
      end else if (fall > cfg.slew_max) begin
        slewed = last_r - cfg.slew_max;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = in_read_failed ? ST_DONE : ST_DIV1;
      ST_DIV1: if (div_done) state_nxt = ST_SQRT;
      ST_SQRT: if (sqrt_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OFS;
      ST_OFS: begin
        if (cfg.offset_index == OFS_MINUS_30 || cfg.offset_index == OFS_PLUS_30)
          state_nxt = ST_DIV2;
        else
          state_nxt = ST_FIN1;
      end
      ST_DIV2: if (div_done) state_nxt = ST_FIN1;
      ST_FIN1: state_nxt = ST_FIN2;
      ST_FIN2: state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      avg_r         <= '0;
      seeded_r      <= 1'b0;
      last_r        <= '0;
      last_seeded_r <= 1'b0;
      fail_cnt_r    <= '0;
      div_start_r   <= 1'b0;
      sqrt_start_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      div_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;
      if (in_xfer) begin
        if (in_read_failed) begin
          fail_cnt_r <= (cnt_inc >= 4'(FAIL_LIMIT)) ? 4'd0 : cnt_inc;
        end else begin
          fail_cnt_r  <= '0;
          avg_r       <= avg_nxt;
          seeded_r    <= 1'b1;
          div_start_r <= 1'b1;
        end
      end
      if (state_r == ST_DIV1 && div_done) sqrt_start_r <= 1'b1;
      if (state_r == ST_OFS && state_nxt == ST_DIV2) div_start_r <= 1'b1;
      if (state_r == ST_FIN2) begin
        last_r        <= slewed;
        last_seeded_r <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                out_valid_r <= 1'b0;
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      failed_r <= in_read_failed;
      raise_r  <= in_read_failed && (cnt_inc >= 4'(FAIL_LIMIT)) && !in_test_mode;
    end
    if (state_r == ST_DIV1 && div_done) low_light_r <= (div_quot <= LOW_LIGHT_LIMIT);
    if (state_r == ST_MUL) base_r <= prod;
    if (state_r == ST_OFS) begin
      cap_r <= cap_sel;
      neg_r <= (cfg.offset_index == OFS_MINUS_50 || cfg.offset_index == OFS_MINUS_30);
      if (cfg.offset_index == OFS_MINUS_50 || cfg.offset_index == OFS_PLUS_50)
        delta_r <= base_r >> 1;
      else
        delta_r <= '0;
    end
    if (state_r == ST_DIV2 && div_done) delta_r <= div_quot[BASE_W-1:0];
    if (state_r == ST_FIN1) tgt_r <= t_full[BRIGHT_W-1:0];
    if (state_r == ST_DONE && out_free) begin
      out_bright_r <= last_r;
      out_bvalid_r <= !failed_r;
      out_lux_r    <= avg_r;
      out_failed_r <= failed_r;
      out_err_r    <= raise_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_brightness       = out_bright_r;
  assign out_brightness_valid = out_bvalid_r;
  assign out_filtered_lux     = out_lux_r;
  assign out_sensor_failed    = out_failed_r;
  assign out_error_raised     = out_err_r;

  a_fail_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_read_failed |=> state_r == ST_DONE)
    else $error("failed read did not go straight to result");

  a_bright_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_bright_r <= BRIGHT_W'(BRIGHT_MAX))
    else $error("brightness above full scale");

  a_err_only_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_failed_r && !out_bvalid_r)
    else $error("error flag on a good read");

  a_fail_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    fail_cnt_r < 4'(FAIL_LIMIT))
    else $error("fail count past limit");

endmodule
